// ----- rtl/u2cp_pkg.sv -----
package u2cp_pkg;

  // Input commands
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  // Byte classes
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_MIN    = 8'hC2;
  localparam logic [7:0] HIT_BASE    = 8'h80;

  // Scan outcomes
  localparam logic [1:0] SCAN_MISS = 2'd0;
  localparam logic [1:0] SCAN_HIT  = 2'd1;
  localparam logic [1:0] SCAN_WAIT = 2'd2;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic start;
    logic have3;
    logic may_wait;
  } scan_ctl_t;

  typedef struct packed {
    logic       done;
    logic [1:0] outcome;
    logic       len3;
  } scan_stat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        stored;
    logic        is_terminator;
    logic [31:0] total_length;
    logic        last;
  } res_t;

endpackage

// ----- rtl/u2cp_in_if.sv -----
interface u2cp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [6:0]  table_index;
  logic [23:0] table_entry;
  logic [7:0]  data_byte;

  modport source (
    output valid, command, table_index, table_entry, data_byte,
    input  ready
  );
  modport sink (
    input  valid, command, table_index, table_entry, data_byte,
    output ready
  );
endinterface

// ----- rtl/u2cp_out_if.sv -----
interface u2cp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        stored;
  logic        is_terminator;
  logic [31:0] total_length;
  logic        last;

  modport source (
    output valid, out_byte, stored, is_terminator, total_length, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, stored, is_terminator, total_length, last,
    output ready
  );
endinterface

// ----- rtl/utf8_to_codepage_converter_unit.sv -----
// A load or an unused command is taken without leaving idle; a data byte or an end item
// drains the window, passing, dropping or converting its bytes, with at most two table scans.
// One table entry is compared per cycle. Results leave through a four-entry queue,
// one per cycle while the receiver is ready; input waits while two or more are queued.
// Reset (rst_ni, asynchronous, active low) clears window, counters, capacity and queue;
// table contents are undefined until loaded.
module utf8_to_codepage_converter_unit #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  u2cp_in_if.sink     in_i,
  u2cp_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import u2cp_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DRAIN  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [2:0][7:0] win_q, win_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            final_q, final_d;
  logic [31:0]     ocnt_q, ocnt_d;
  logic [15:0]     cap_q, cap_d;
  res_t            hold_q, hold_d;
  logic            hold_vld_q, hold_vld_d;

  logic            accept;
  logic            emit, emit_term;
  logic [7:0]      emit_byte;
  res_t            emit_res;
  logic            push;
  res_t            push_data;
  logic [QCW-1:0]  q_count;
  logic            pop_en;
  logic [1:0]      pop_n;

  scan_ctl_t       scan_ctl;
  scan_stat_t      scan_stat;
  logic [AW-1:0]   hit_idx;
  logic            tbl_we;

  function automatic logic [2:0][7:0] shift_win(input logic [2:0][7:0] w,
                                                input logic [1:0] n);
    logic [2:0][7:0] r;
    case (n)
      2'd1:    r = {8'h00, w[2], w[1]};
      2'd2:    r = {16'h0000, w[2]};
      2'd3:    r = '0;
      default: r = w;
    endcase
    return r;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'h0000, cap_q} : 32'h0000_0000;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && paddr == 2'd0) begin
      cap_d = pwdata[15:0];
    end
  end

  // input handshake
  assign in_i.ready = (state_q == S_IDLE) && (q_count <= QCW'(QDEPTH - 3));
  assign accept     = in_i.valid && in_i.ready;

  assign tbl_we = accept && in_i.command == CMD_LOAD &&
                  ({1'b0, in_i.table_index} < 8'(TABLE_ENTRIES));

  u2cp_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .lead_i    (win_q[0]),
    .second_i  (win_q[1]),
    .third_i   (win_q[2]),
    .wr_en_i   (tbl_we),
    .wr_addr_i (in_i.table_index[AW-1:0]),
    .wr_data_i (in_i.table_entry),
    .stat_o    (scan_stat),
    .hit_idx_o (hit_idx)
  );

  // result fields for the byte being emitted
  always_comb begin
    emit_res               = '0;
    emit_res.is_terminator = emit_term;
    if (emit_term) begin
      emit_res.stored       = (cap_q != 16'h0000);
      emit_res.total_length = ocnt_q;
    end else begin
      emit_res.out_byte = emit_byte;
      emit_res.stored   = (cap_q != 16'h0000) && (ocnt_q < ({16'h0000, cap_q} - 32'd1));
    end
  end

  // main sequencer
  always_comb begin
    state_d        = state_q;
    win_d          = win_q;
    cnt_d          = cnt_q;
    final_d        = final_q;
    ocnt_d         = ocnt_q;
    emit           = 1'b0;
    emit_term      = 1'b0;
    emit_byte      = 8'h00;
    pop_en         = 1'b0;
    pop_n          = 2'd1;
    scan_ctl       = '0;
    scan_ctl.have3 = (cnt_q == 2'd3);
    scan_ctl.may_wait = !final_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.command)
            CMD_DATA: begin
              if (cnt_q != 2'd3) begin
                win_d[cnt_q] = in_i.data_byte;
                cnt_d        = cnt_q + 2'd1;
              end
              state_d = S_DRAIN;
            end
            CMD_END: begin
              final_d = 1'b1;
              state_d = S_DRAIN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // one window step per cycle; multi-byte leads hand over to the scan
      S_DRAIN: begin
        if (cnt_q == 2'd0) begin
          if (final_q) begin
            emit      = 1'b1;
            emit_term = 1'b1;
            win_d     = '0;
            cnt_d     = 2'd0;
            ocnt_d    = 32'd0;
            final_d   = 1'b0;
          end
          state_d = S_FINISH;
        end else if (win_q[0] < ASCII_LIMIT) begin
          emit      = 1'b1;
          emit_byte = win_q[0];
          pop_en    = 1'b1;
        end else if (win_q[0] < LEAD_MIN) begin
          pop_en = 1'b1;
        end else if (cnt_q < 2'd2) begin
          if (final_q) begin
            pop_en = 1'b1;
          end else begin
            state_d = S_FINISH;
          end
        end else begin
          scan_ctl.start = 1'b1;
          state_d        = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_stat.done) begin
          case (scan_stat.outcome)
            SCAN_HIT: begin
              emit      = 1'b1;
              emit_byte = HIT_BASE | 8'(hit_idx);
              pop_en    = 1'b1;
              pop_n     = scan_stat.len3 ? 2'd3 : 2'd2;
              state_d   = S_DRAIN;
            end
            SCAN_WAIT: begin
              state_d = S_FINISH;
            end
            default: begin
              pop_en  = 1'b1;
              state_d = S_DRAIN;
            end
          endcase
        end
      end

      S_FINISH: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (pop_en) begin
      win_d = shift_win(win_q, pop_n);
      cnt_d = cnt_q - pop_n;
    end

    // saturating count of emitted bytes
    if (emit && !emit_term && ocnt_q != 32'hFFFF_FFFF) begin
      ocnt_d = ocnt_q + 32'd1;
    end
  end

  // hold the newest result back until we know whether it is the last one
  always_comb begin
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    push       = 1'b0;
    push_data  = hold_q;
    if (emit) begin
      push       = hold_vld_q;
      hold_d     = emit_res;
      hold_vld_d = 1'b1;
    end else if (state_q == S_FINISH && hold_vld_q) begin
      push           = 1'b1;
      push_data.last = 1'b1;
      hold_vld_d     = 1'b0;
    end
  end

  u2cp_rqueue u_rqueue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .count_o     (q_count),
    .out_o       (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      win_q      <= '0;
      cnt_q      <= 2'd0;
      final_q    <= 1'b0;
      ocnt_q     <= 32'd0;
      cap_q      <= 16'h0000;
      hold_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      win_q      <= win_d;
      cnt_q      <= cnt_d;
      final_q    <= final_d;
      ocnt_q     <= ocnt_d;
      cap_q      <= cap_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  // held result payload, no reset
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule

// ----- rtl/u2cp_ram.sv -----
module u2cp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/u2cp_scan.sv -----
module u2cp_scan #(
  parameter int unsigned TABLE_ENTRIES = 128,
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  u2cp_pkg::scan_ctl_t    ctl_i,
  input  logic [7:0]             lead_i,
  input  logic [7:0]             second_i,
  input  logic [7:0]             third_i,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [23:0]            wr_data_i,
  output u2cp_pkg::scan_stat_t   stat_o,
  output logic [AW-1:0]          hit_idx_o
);

  import u2cp_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  logic          busy_q, busy_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] raddr;
  logic [23:0]   rdata;
  logic          pair_match;
  scan_stat_t    stat;

  u2cp_ram #(
    .WIDTH (24),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // read one entry ahead of the one being compared
  assign raddr = (ctl_i.start || idx_q == LAST_IDX) ? '0 : idx_q + AW'(1);

  // compare the entry read last cycle against the window
  assign pair_match = (rdata[7:0] == lead_i) && (rdata[15:8] == second_i);

  always_comb begin
    stat = '0;
    if (busy_q && pair_match) begin
      if (rdata[23:16] == 8'h00) begin
        stat.done    = 1'b1;
        stat.outcome = SCAN_HIT;
      end else if (ctl_i.have3 && rdata[23:16] == third_i) begin
        stat.done    = 1'b1;
        stat.outcome = SCAN_HIT;
        stat.len3    = 1'b1;
      end else if (!ctl_i.have3 && ctl_i.may_wait) begin
        stat.done    = 1'b1;
        stat.outcome = SCAN_WAIT;
      end
    end
    if (busy_q && !stat.done && idx_q == LAST_IDX) begin
      stat.done    = 1'b1;
      stat.outcome = SCAN_MISS;
    end
  end

  // sequencing of the entry counter
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      if (stat.done) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  assign stat_o    = stat;
  assign hit_idx_o = idx_q;

endmodule

// ----- rtl/u2cp_rqueue.sv -----
module u2cp_rqueue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  u2cp_pkg::res_t             push_data_i,
  output logic [u2cp_pkg::QCW-1:0]   count_o,
  u2cp_out_if.source                 out_o
);

  import u2cp_pkg::*;

  res_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           pop;
  res_t           head;

  assign pop  = out_o.valid && out_o.ready;
  assign head = entries[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QAW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + QAW'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_o.valid         = (cnt_q != '0);
  assign out_o.out_byte      = head.out_byte;
  assign out_o.stored        = head.stored;
  assign out_o.is_terminator = head.is_terminator;
  assign out_o.total_length  = head.total_length;
  assign out_o.last          = head.last;
  assign count_o             = cnt_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import u2cp_pkg::*;

  localparam int unsigned TBL         = 128;
  localparam int unsigned SETTLE_CYC  = 2 * TBL + 16;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 40;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [1:0]  CAP_ADDR    = 2'd0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  idx;
    logic [23:0] entry;
    logic [7:0]  data;
  } u2cp_item_t;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // Channels and configuration port
  u2cp_in_if  in_if ();
  u2cp_out_if out_if ();

  logic        drv_valid = 1'b0;
  logic [1:0]  drv_cmd   = CMD_LOAD;
  logic [6:0]  drv_idx   = '0;
  logic [23:0] drv_entry = '0;
  logic [7:0]  drv_data  = '0;
  logic        mon_ready = 1'b0;

  logic        p_sel   = 1'b0;
  logic        p_en    = 1'b0;
  logic        p_wr    = 1'b0;
  logic [1:0]  p_addr  = CAP_ADDR;
  logic [31:0] p_wdata = '0;
  logic [31:0] prdata_w;
  logic        pready_w;

  assign in_if.valid       = drv_valid;
  assign in_if.command     = drv_cmd;
  assign in_if.table_index = drv_idx;
  assign in_if.table_entry = drv_entry;
  assign in_if.data_byte   = drv_data;
  assign out_if.ready      = mon_ready;

  utf8_to_codepage_converter_unit #(
    .TABLE_ENTRIES(TBL)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (p_sel),
    .penable (p_en),
    .pwrite  (p_wr),
    .paddr   (p_addr),
    .pwdata  (p_wdata),
    .prdata  (prdata_w),
    .pready  (pready_w)
  );

  // Converter mirror state
  logic [23:0] lut [TBL];
  logic [7:0]  win [3];
  int unsigned win_cnt = 0;
  logic [31:0] out_cnt = '0;
  logic [15:0] cap     = '0;

  res_t        item_res [$];
  res_t        expected_out [$];
  u2cp_item_t  pend_items [$];
  int unsigned err_cnt    = 0;
  int unsigned queued_cnt = 0;
  bit          calm       = 1'b0;

  function automatic void log_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endfunction

  // Mostly short gaps, a few long ones; none in a calm phase
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One output byte or the terminator; at most three per transaction
  function automatic void put_result(logic [7:0] value, bit term);
    res_t r;
    if (item_res.size() >= 3) return;
    r = '0;
    if (term) begin
      r.stored        = (cap != 16'd0);
      r.is_terminator = 1'b1;
      r.total_length  = out_cnt;
    end else begin
      r.out_byte = value;
      r.stored   = (cap != 16'd0) && (out_cnt < {16'd0, cap} - 32'd1);
      if (out_cnt != 32'hFFFF_FFFF) out_cnt++;
    end
    item_res.push_back(r);
  endfunction

  function automatic void shift_win(int unsigned n);
    int unsigned k;
    k = (n > win_cnt) ? win_cnt : n;
    for (int i = 0; i < 3; i++) win[i] = (i + k < 3) ? win[i + k] : 8'h00;
    win_cnt -= k;
  endfunction

  // First matching entry in table order
  function automatic logic [1:0] lookup(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input bit have3,
                                        input bit may_wait, output int unsigned hit_idx,
                                        output int unsigned hit_len);
    logic [23:0] e;
    hit_idx = 0;
    hit_len = 1;
    for (int i = 0; i < TBL; i++) begin
      e = lut[i];
      if (e[7:0] != b0 || e[15:8] != b1) continue;
      if (e[23:16] == 8'h00) begin
        hit_idx = i;
        hit_len = 2;
        return SCAN_HIT;
      end
      if (have3) begin
        if (e[23:16] == b2) begin
          hit_idx = i;
          hit_len = 3;
          return SCAN_HIT;
        end
      end else if (may_wait) begin
        return SCAN_WAIT;
      end
    end
    return SCAN_MISS;
  endfunction

  function automatic void resolve_window(bit flush);
    logic [7:0]  h;
    logic [1:0]  outcome;
    int unsigned ix;
    int unsigned ln;
    while (win_cnt > 0) begin
      h = win[0];
      if (h < ASCII_LIMIT) begin
        put_result(h, 1'b0);
        shift_win(1);
        continue;
      end
      if (h < LEAD_MIN) begin
        shift_win(1);
        continue;
      end
      if (win_cnt < 2) begin
        if (flush) begin
          shift_win(1);
          continue;
        end
        break;
      end
      outcome = lookup(h, win[1], win[2], win_cnt >= 3, !flush, ix, ln);
      if (outcome == SCAN_WAIT) break;
      if (outcome == SCAN_HIT) begin
        put_result(HIT_BASE + ix[7:0], 1'b0);
        shift_win(ln);
      end else begin
        shift_win(1);
      end
    end
  endfunction

  // Expected results of one accepted input transaction
  function automatic void convert_item(u2cp_item_t it);
    item_res.delete();
    case (it.cmd)
      CMD_LOAD: begin
        lut[it.idx] = it.entry;
      end
      CMD_DATA: begin
        if (win_cnt < 3) begin
          win[win_cnt] = it.data;
          win_cnt++;
        end
        resolve_window(1'b0);
      end
      CMD_END: begin
        resolve_window(1'b1);
        put_result(8'h00, 1'b1);
        for (int i = 0; i < 3; i++) win[i] = 8'h00;
        win_cnt = 0;
        out_cnt = '0;
      end
      default: begin
      end
    endcase
    if (item_res.size() > 0) item_res[item_res.size() - 1].last = 1'b1;
    foreach (item_res[i]) expected_out.push_back(item_res[i]);
  endfunction

  // Input driver
  int unsigned src_wait = 0;

  always @(posedge clk_i) begin : src_drv
    bit held;
    if (rst_n) begin
      if (drv_valid && in_if.ready) begin
        convert_item(pend_items.pop_front());
        src_wait = pick_gap();
      end
      held = drv_valid && !in_if.ready;
      if (!held) begin
        if (src_wait > 0) begin
          src_wait--;
          drv_valid <= 1'b0;
        end else if (pend_items.size() > 0) begin
          drv_valid <= 1'b1;
          drv_cmd   <= pend_items[0].cmd;
          drv_idx   <= pend_items[0].idx;
          drv_entry <= pend_items[0].entry;
          drv_data  <= pend_items[0].data;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  int unsigned sink_wait = 0;

  always @(posedge clk_i) begin : sink_mon
    res_t got;
    res_t want;
    if (rst_n) begin
      if (out_if.valid && mon_ready) begin
        got.out_byte      = out_if.out_byte;
        got.stored        = out_if.stored;
        got.is_terminator = out_if.is_terminator;
        got.total_length  = out_if.total_length;
        got.last          = out_if.last;
        if (expected_out.size() == 0) begin
          log_error($sformatf("unexpected result byte=%h term=%b len=%0d",
                              got.out_byte, got.is_terminator, got.total_length));
        end else begin
          want = expected_out.pop_front();
          if (got.out_byte !== want.out_byte || got.stored !== want.stored ||
              got.is_terminator !== want.is_terminator ||
              got.total_length !== want.total_length || got.last !== want.last) begin
            log_error($sformatf({"result mismatch exp byte=%h st=%b term=%b len=%0d last=%b",
                                 " got byte=%h st=%b term=%b len=%0d last=%b"},
                                want.out_byte, want.stored, want.is_terminator,
                                want.total_length, want.last, got.out_byte, got.stored,
                                got.is_terminator, got.total_length, got.last));
          end
        end
        sink_wait = pick_gap();
      end
      if (sink_wait > 0) begin
        sink_wait--;
        mon_ready <= 1'b0;
      end else begin
        mon_ready <= 1'b1;
      end
    end
  end

  // Stall watchdog
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: %0d results outstanding", expected_out.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus helpers
  task automatic q_load(input logic [6:0] idx, input logic [23:0] entry);
    pend_items.push_back('{cmd: CMD_LOAD, idx: idx, entry: entry, data: 8'h00});
    queued_cnt++;
  endtask

  task automatic q_byte(input logic [7:0] b);
    pend_items.push_back('{cmd: CMD_DATA, idx: 7'd0, entry: 24'd0, data: b});
    queued_cnt++;
  endtask

  task automatic q_cmd(input logic [1:0] cmd);
    pend_items.push_back('{cmd: cmd, idx: 7'd0, entry: 24'd0, data: 8'h00});
    if (cmd != CMD_UNUSED) queued_cnt++;
  endtask

  // Mostly well-formed patterns over a small alphabet, some fully random
  function automatic logic [23:0] rand_entry();
    logic [31:0] w;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    w = $urandom();
    if ($urandom_range(0, 7) == 0) return w[23:0];
    case ($urandom_range(0, 3))
      0: b0 = 8'hC2;
      1: b0 = 8'hC3;
      2: b0 = 8'hE2;
      default: b0 = 8'hEF;
    endcase
    b1 = 8'h80 + w[2:0];
    b2 = w[3] ? 8'h00 : (8'h80 + w[6:4]);
    return {b2, b1, b0};
  endfunction

  // One character of text: ASCII, a table pattern, a truncated one or noise
  task automatic q_char();
    int unsigned k;
    logic [23:0] e;
    k = $urandom_range(0, 99);
    e = lut[7'($urandom_range(0, TBL - 1))];
    if (k < 30) begin
      q_byte(8'($urandom_range(0, 127)));
    end else if (k < 70) begin
      q_byte(e[7:0]);
      q_byte(e[15:8]);
      if (e[23:16] != 8'h00) q_byte(e[23:16]);
    end else if (k < 80) begin
      q_byte(e[7:0]);
      q_byte(e[15:8]);
    end else if (k < 90) begin
      q_byte(8'($urandom_range(0, 255)));
    end else begin
      q_byte(8'($urandom_range(128, 193)));
    end
  endtask

  // Sender holds off until the converter has drained
  task automatic settle();
    while (pend_items.size() != 0 || drv_valid || expected_out.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // APB write of the capacity register, then read back
  task automatic set_capacity(input logic [15:0] val);
    @(posedge clk_i);
    p_sel   <= 1'b1;
    p_en    <= 1'b0;
    p_wr    <= 1'b1;
    p_addr  <= CAP_ADDR;
    p_wdata <= {16'd0, val};
    @(posedge clk_i);
    p_en <= 1'b1;
    do @(posedge clk_i); while (!pready_w);
    p_wr <= 1'b0;
    p_en <= 1'b0;
    cap = val;
    @(posedge clk_i);
    p_en <= 1'b1;
    do @(posedge clk_i); while (!pready_w);
    if (prdata_w[15:0] !== val)
      log_error($sformatf("capacity readback exp %h got %h", val, prdata_w[15:0]));
    p_sel <= 1'b0;
    p_en  <= 1'b0;
  endtask

  // Main sequence
  initial begin : stimulus
    logic [15:0] caps [6];
    int unsigned phase_start;
    int unsigned len;
    while (!rst_n) @(posedge clk_i);
    @(posedge clk_i);

    // Whole table loaded first so no scan reads an unwritten entry
    for (int i = 0; i < TBL; i++) begin
      case (i)
        0:       q_load(7'(i), 24'h00A9C2);
        1:       q_load(7'(i), 24'hA280E2);
        2:       q_load(7'(i), 24'h0080E2);
        TBL - 1: q_load(7'(i), 24'hAC82E2);
        default: q_load(7'(i), rand_entry());
      endcase
    end

    // Directed part at reset capacity (nothing stored)
    q_byte(8'h00);
    q_byte(8'h7F);
    q_byte(8'h80);
    q_byte(8'hC1);
    q_byte(8'hC2);
    q_byte(8'hA9);
    // 3-byte entry ahead of a 2-byte one: waits, then full hit
    q_byte(8'hE2);
    q_byte(8'h80);
    q_byte(8'hA2);
    // same pair, third byte misses: falls back to the 2-byte entry
    q_byte(8'hE2);
    q_byte(8'h80);
    q_byte(8'h41);
    q_byte(8'hE2);
    q_byte(8'h82);
    q_byte(8'hAC);
    // end with a lone lead, then with a pair pending
    q_byte(8'hC3);
    q_cmd(CMD_END);
    q_byte(8'hE2);
    q_byte(8'h80);
    q_cmd(CMD_END);
    q_cmd(CMD_UNUSED);
    q_cmd(CMD_END);
    q_byte(8'hFF);
    q_byte(8'h20);
    q_cmd(CMD_END);
    settle();

    caps[0] = 16'd2;
    caps[1] = 16'd1;
    caps[2] = 16'hFFFF;
    caps[3] = 16'd0;
    caps[4] = 16'($urandom_range(3, 30));
    caps[5] = 16'($urandom_range(0, 65535));

    foreach (caps[p]) begin
      set_capacity(caps[p]);
      calm = (p == 3);
      phase_start = queued_cnt;
      while (queued_cnt - phase_start < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 8);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 19) == 0) q_load(7'($urandom_range(0, TBL - 1)), rand_entry());
          q_char();
        end
        if ($urandom_range(0, 24) == 0) q_cmd(CMD_UNUSED);
        q_cmd(CMD_END);
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
